### rtl/core/four_axis_step_command_sequencer_assert.svh
// Assertion macros for the four-axis step command sequencer.
// Included by fasq_queue, the RTL file that carries concurrent checks; no dependencies.
`ifndef FOUR_AXIS_STEP_COMMAND_SEQUENCER_ASSERT_SVH
`define FOUR_AXIS_STEP_COMMAND_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define FASQ_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("fasq check failed");

// Next-cycle implication, disabled while in reset.
`define FASQ_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("fasq check failed");

`endif

### rtl/core/fasq_pkg.sv
// Package for the four-axis step command sequencer: sizes, codes and the
// queued operation type. No dependencies.
`default_nettype none
package fasq_pkg;

  localparam int MOTOR_COUNT = 4;
  localparam int COUNT_WIDTH = 24;
  localparam int MOTOR_IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  localparam int LINE_COUNT = 4;
  localparam int HALF_COUNT = 4;
  localparam int REG_W      = 8;
  localparam int DELTA_W    = 2 * REG_W;
  localparam int CFG_IDX_W  = 3;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  localparam logic [REG_W-1:0] MULT_RST  = 8'd19;
  localparam logic [REG_W-1:0] HALF1_RST = 8'd1;
  localparam logic [REG_W-1:0] HALF2_RST = 8'd1;
  localparam logic [REG_W-1:0] HALF3_RST = 8'd75;
  localparam logic [REG_W-1:0] HALF4_RST = 8'd1;

  localparam logic [CFG_IDX_W-1:0] REG_MULT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HALF4 = 3'd4;

  localparam logic [7:0] CODE_M = 8'h4D;
  localparam logic [7:0] CODE_P = 8'h50;
  localparam logic [7:0] CODE_T = 8'h54;

  localparam logic [1:0] OP_NOP    = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_MOVE   = 2'd2;
  localparam logic [1:0] OP_TOGGLE = 2'd3;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;

  typedef struct packed {
    logic [1:0]             op;
    logic [MOTOR_IDX_W-1:0] motor;
    logic                   add;
    logic [DELTA_W-1:0]     delta;
  } cmd_t;

endpackage
`default_nettype wire

### rtl/core/fasq_front.sv
// Front end: accepts input transactions and decodes them into queued ops.
// Depends on fasq_pkg.
`default_nettype none
module fasq_front (
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [fasq_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic                       in_tuser,
  input  wire logic [fasq_pkg::REG_W-1:0] step_mult,
  output logic                            push_valid,
  input  wire logic                       push_ready,
  output fasq_pkg::cmd_t                  push_data
);
  import fasq_pkg::*;

  logic [7:0] code;
  logic [7:0] dm;
  logic [7:0] amount;
  logic [7:0] mv_idx;
  logic [7:0] tg_idx;

  assign code   = in_tdata[7:0];
  assign dm     = in_tdata[15:8];
  assign amount = in_tdata[23:16];
  assign mv_idx = code - CODE_M;
  assign tg_idx = dm - 8'd1;

  assign in_tready  = push_ready;
  assign push_valid = in_tvalid;

  always_comb begin
    push_data.op    = OP_NOP;
    push_data.motor = '0;
    push_data.add   = (dm != 8'd0);
    push_data.delta = DELTA_W'(amount) * DELTA_W'(step_mult);
    if (in_tuser) begin
      push_data.op = OP_TICK;
    end else if (code inside {[CODE_M:CODE_P]}) begin
      if (mv_idx < 8'(MOTOR_COUNT)) begin
        push_data.op    = OP_MOVE;
        push_data.motor = mv_idx[MOTOR_IDX_W-1:0];
      end
    end else if (code == CODE_T) begin
      if (dm >= 8'd1 && dm <= 8'(MOTOR_COUNT)) begin
        push_data.op    = OP_TOGGLE;
        push_data.motor = tg_idx[MOTOR_IDX_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/fasq_queue.sv
// Short FIFO of decoded ops between front end and back end.
// Depends on fasq_pkg and the assertion macro header.
`default_nettype none
module fasq_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire fasq_pkg::cmd_t push_data,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output fasq_pkg::cmd_t      pop_data
);
  import fasq_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;
  logic              pop;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = QCNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = QCNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`include "four_axis_step_command_sequencer_assert.svh"

  `FASQ_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, count_r <= QCNT_W'(QDEPTH))
  `FASQ_ASSERT_IMP(a_ptr_gap, clk, rst_n, count_r == '0 || count_r == QCNT_W'(QDEPTH),
                   wr_ptr_r == rd_ptr_r)
  `FASQ_ASSERT_NXT(a_cnt_track, clk, rst_n, push && !pop, count_r == $past(count_r) + 1'b1)

endmodule
`default_nettype wire

### rtl/core/fasq_back.sv
// Back end: applies queued ops to the motor state and registers one result
// per op. Depends on fasq_pkg.
`default_nettype none
module fasq_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        pop_valid,
  output logic                             pop_ready,
  input  wire fasq_pkg::cmd_t              pop_data,
  input  wire logic [fasq_pkg::REG_W-1:0]  half_period [fasq_pkg::HALF_COUNT],
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [fasq_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import fasq_pkg::*;

  logic signed [COUNT_WIDTH-1:0] cnt_r   [MOTOR_COUNT];
  logic signed [COUNT_WIDTH-1:0] cnt_nxt [MOTOR_COUNT];
  logic [1:0]       phase_r [MOTOR_COUNT];
  logic [1:0]       phase_nxt [MOTOR_COUNT];
  logic [REG_W-1:0] wait_r [MOTOR_COUNT];
  logic [REG_W-1:0] wait_nxt [MOTOR_COUNT];
  logic [MOTOR_COUNT-1:0] step_r, step_nxt;
  logic [MOTOR_COUNT-1:0] dir_r, dir_nxt;
  logic [MOTOR_COUNT-1:0] dis_r, dis_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]  out_data_r, out_data_nxt;
  logic                   advance;

  assign pop_ready  = !out_valid_r || out_tready;
  assign advance    = pop_valid && pop_ready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    logic [REG_W-1:0]          hp;
    logic [REG_W-1:0]          w;
    logic signed [COUNT_WIDTH:0] sum;
    logic signed [COUNT_WIDTH:0] dx;
    logic                      busy;
    logic [LINE_COUNT-1:0]     s4;
    logic [LINE_COUNT-1:0]     d4;
    logic [LINE_COUNT-1:0]     x4;
    step_nxt = step_r;
    dir_nxt  = dir_r;
    dis_nxt  = dis_r;
    busy     = 1'b0;
    for (int m = 0; m < MOTOR_COUNT; m++) begin
      cnt_nxt[m]   = cnt_r[m];
      phase_nxt[m] = phase_r[m];
      wait_nxt[m]  = wait_r[m];
      hp = half_period[(m < HALF_COUNT) ? m : HALF_COUNT - 1];
      if (hp == '0) begin
        hp = REG_W'(1);
      end
      w   = (wait_r[m] != '0) ? REG_W'(wait_r[m] - 1'b1) : '0;
      dx  = signed'({{(COUNT_WIDTH + 1 - DELTA_W){1'b0}}, pop_data.delta});
      sum = pop_data.add ? ({cnt_r[m][COUNT_WIDTH-1], cnt_r[m]} + dx)
                         : ({cnt_r[m][COUNT_WIDTH-1], cnt_r[m]} - dx);
      case (pop_data.op)
        OP_TICK: begin
          if (phase_r[m] == PH_HIGH) begin
            wait_nxt[m] = w;
            if (w == '0) begin
              step_nxt[m]  = 1'b0;
              phase_nxt[m] = PH_LOW;
              wait_nxt[m]  = hp;
            end
          end else if (phase_r[m] == PH_LOW) begin
            wait_nxt[m] = w;
            if (w == '0) begin
              phase_nxt[m] = PH_IDLE;
            end
          end else begin
            phase_nxt[m] = PH_IDLE;
          end
          if (phase_nxt[m] == PH_IDLE && cnt_r[m] != '0) begin
            dir_nxt[m]   = !cnt_r[m][COUNT_WIDTH-1];
            cnt_nxt[m]   = cnt_r[m][COUNT_WIDTH-1] ? COUNT_WIDTH'(cnt_r[m] + 1'b1)
                                                   : COUNT_WIDTH'(cnt_r[m] - 1'b1);
            step_nxt[m]  = 1'b1;
            phase_nxt[m] = PH_HIGH;
            wait_nxt[m]  = hp;
          end
        end
        OP_MOVE: begin
          if (pop_data.motor == MOTOR_IDX_W'(m)) begin
            if (sum[COUNT_WIDTH] != sum[COUNT_WIDTH-1]) begin
              // saturate toward the sign of the true sum
              cnt_nxt[m] = sum[COUNT_WIDTH] ? {1'b1, {(COUNT_WIDTH-1){1'b0}}}
                                            : {1'b0, {(COUNT_WIDTH-1){1'b1}}};
            end else begin
              cnt_nxt[m] = sum[COUNT_WIDTH-1:0];
            end
          end
        end
        OP_TOGGLE: begin
          if (pop_data.motor == MOTOR_IDX_W'(m)) begin
            dis_nxt[m] = !dis_r[m];
          end
        end
        default: begin
        end
      endcase
      if (cnt_nxt[m] != '0 || phase_nxt[m] != PH_IDLE) begin
        busy = 1'b1;
      end
    end
    s4 = '0;
    d4 = '0;
    x4 = '0;
    for (int i = 0; i < LINE_COUNT && i < MOTOR_COUNT; i++) begin
      s4[i] = step_nxt[i];
      d4[i] = dir_nxt[i];
      x4[i] = dis_nxt[i];
    end
    out_data_nxt  = OUT_DATA_W'({busy, x4, d4, s4});
    out_valid_nxt = advance ? 1'b1 : (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < MOTOR_COUNT; m++) begin
        cnt_r[m]   <= '0;
        phase_r[m] <= PH_IDLE;
        wait_r[m]  <= '0;
      end
      step_r      <= '0;
      dir_r       <= '0;
      dis_r       <= '1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        for (int m = 0; m < MOTOR_COUNT; m++) begin
          cnt_r[m]   <= cnt_nxt[m];
          phase_r[m] <= phase_nxt[m];
          wait_r[m]  <= wait_nxt[m];
        end
        step_r <= step_nxt;
        dir_r  <= dir_nxt;
        dis_r  <= dis_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/core/four_axis_step_command_sequencer.sv
// Four-axis step command sequencer: accepts one input transaction per cycle
// while the queue has room and returns one result transaction for each.
// The front end decodes and scales moves (one 8x8 multiply), a
// four-entry queue decouples it from the back end, and the back end updates
// all four motor counters and pulse timers for one queued op per cycle, so
// sustained rate is one transaction per clock while the result side keeps up.
// Configuration writes go straight to the registers; no reset pass is needed.
`default_nettype none
module four_axis_step_command_sequencer (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // code[7:0], direction_or_motor[15:8], amount[23:16]
  input  wire logic [fasq_pkg::IN_DATA_W-1:0]     in_tdata,
  // command (0 message, 1 tick)
  input  wire logic                               in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // step_lines[3:0], dir_lines[7:4], disable_lines[11:8], busy_res[12], zero
  output logic [fasq_pkg::OUT_DATA_W-1:0]         out_tdata,
  input  wire logic                               cfg_we,
  input  wire logic [fasq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fasq_pkg::REG_W-1:0]         cfg_wdata
);
  import fasq_pkg::*;

  logic [REG_W-1:0] mult_r;
  logic [REG_W-1:0] half_r [HALF_COUNT];
  logic             push_valid;
  logic             push_ready;
  cmd_t             push_data;
  logic             pop_valid;
  logic             pop_ready;
  cmd_t             pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r    <= MULT_RST;
      half_r[0] <= HALF1_RST;
      half_r[1] <= HALF2_RST;
      half_r[2] <= HALF3_RST;
      half_r[3] <= HALF4_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MULT:  mult_r    <= cfg_wdata;
        REG_HALF1: half_r[0] <= cfg_wdata;
        REG_HALF2: half_r[1] <= cfg_wdata;
        REG_HALF3: half_r[2] <= cfg_wdata;
        REG_HALF4: half_r[3] <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  fasq_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .step_mult  (mult_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  fasq_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  fasq_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .half_period (half_r),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule
`default_nettype wire

### test/tb_four_axis_step_command_sequencer.sv
// Self-checking testbench for four_axis_step_command_sequencer: directed table, then random
// command/tick streams under several register settings, checked against a built-in predictor.
// Depends on fasq_pkg and the sequencer RTL only.
module tb_four_axis_step_command_sequencer;
  import fasq_pkg::*;

  localparam int SETTLE = 8;
  localparam int QUIET_LIMIT = 2000;
  localparam logic [7:0] CODE_N = CODE_M + 8'd1;
  localparam logic [7:0] CODE_O = CODE_M + 8'd2;
  localparam longint STEP_MAX = (longint'(1) <<< (COUNT_WIDTH - 1)) - 1;
  localparam longint STEP_MIN = -STEP_MAX - 1;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER [5] =
    '{REG_MULT, REG_HALF1, REG_HALF2, REG_HALF3, REG_HALF4};

  typedef struct packed {
    logic [3:0] step;
    logic [3:0] dir;
    logic [3:0] dis;
    logic       busy;
  } levels_t;

  typedef struct packed {
    logic       tick;
    logic [7:0] code;
    logic [7:0] arg;
    logic [7:0] amt;
    logic       typed;
    levels_t    want;
  } script_row_t;

  localparam levels_t AT_RESET = '{4'h0, 4'h0, 4'hF, 1'b0};

  // rows with typed == 1 carry a hand-computed result; others use the predictor
  localparam script_row_t SCRIPT [25] = '{
    '{1'b1, 8'h00, 8'h00, 8'h00, 1'b1, AT_RESET},
    '{1'b0, 8'h00, 8'h00, 8'h00, 1'b1, AT_RESET},
    '{1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1, AT_RESET},
    '{1'b0, CODE_M - 8'd1, 8'h01, 8'h05, 1'b1, AT_RESET},
    '{1'b0, CODE_P + 8'd1, 8'h01, 8'h05, 1'b1, AT_RESET},
    '{1'b0, CODE_T, 8'h00, 8'h00, 1'b1, AT_RESET},
    '{1'b0, CODE_T, 8'h05, 8'h00, 1'b1, AT_RESET},
    '{1'b0, CODE_T, 8'hFF, 8'hFF, 1'b1, AT_RESET},
    '{1'b0, CODE_T, 8'h01, 8'h00, 1'b1, '{4'h0, 4'h0, 4'hE, 1'b0}},
    '{1'b0, CODE_T, 8'h04, 8'h00, 1'b1, '{4'h0, 4'h0, 4'h6, 1'b0}},
    '{1'b0, CODE_T, 8'h02, 8'h00, 1'b1, '{4'h0, 4'h0, 4'h4, 1'b0}},
    '{1'b0, CODE_T, 8'h03, 8'h00, 1'b1, '{4'h0, 4'h0, 4'h0, 1'b0}},
    '{1'b0, CODE_M, 8'h01, 8'hFF, 1'b1, '{4'h0, 4'h0, 4'h0, 1'b1}},
    '{1'b1, 8'h00, 8'h00, 8'h00, 1'b1, '{4'h1, 4'h1, 4'h0, 1'b1}},
    '{1'b1, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0},
    '{1'b0, CODE_N, 8'h00, 8'hFF, 1'b0, '0},
    '{1'b0, CODE_O, 8'h80, 8'h01, 1'b0, '0},
    '{1'b0, CODE_P, 8'hFF, 8'h00, 1'b0, '0},
    '{1'b1, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{1'b1, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{1'b0, CODE_M, 8'h00, 8'hFF, 1'b0, '0},
    '{1'b1, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{1'b0, CODE_T, 8'h01, 8'h00, 1'b0, '0},
    '{1'b1, 8'h00, 8'h00, 8'h00, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_wdata = '0;

  four_axis_step_command_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [7:0] mult_shadow = MULT_RST;
  logic [7:0] half_shadow [MOTOR_COUNT] = '{HALF1_RST, HALF2_RST, HALF3_RST, HALF4_RST};
  logic signed [COUNT_WIDTH-1:0] steps_left [MOTOR_COUNT] = '{default: '0};
  logic [1:0] phase [MOTOR_COUNT] = '{default: PH_IDLE};
  logic [7:0] ticks_left [MOTOR_COUNT] = '{default: '0};
  logic [3:0] step_lv = 4'h0;
  logic [3:0] dir_lv = 4'h0;
  logic [3:0] dis_lv = 4'hF;

  levels_t pending_levels [$];
  int mismatch_count = 0;
  int quiet_cycles = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  function automatic logic [7:0] half_ticks(int m);
    return (half_shadow[m] == 8'd0) ? 8'd1 : half_shadow[m];
  endfunction

  function automatic levels_t advance_sequencer(logic is_tick, logic [7:0] code,
                                                logic [7:0] arg, logic [7:0] amt);
    levels_t r;
    longint acc;
    longint delta;
    int m;
    if (is_tick) begin
      for (m = 0; m < MOTOR_COUNT; m++) begin
        if (phase[m] == PH_HIGH) begin
          if (ticks_left[m] != 8'd0) ticks_left[m]--;
          if (ticks_left[m] == 8'd0) begin
            step_lv[m] = 1'b0;
            phase[m] = PH_LOW;
            ticks_left[m] = half_ticks(m);
          end
        end else if (phase[m] == PH_LOW) begin
          if (ticks_left[m] != 8'd0) ticks_left[m]--;
          if (ticks_left[m] == 8'd0) phase[m] = PH_IDLE;
        end
        if (phase[m] == PH_IDLE && steps_left[m] != 0) begin
          dir_lv[m] = (steps_left[m] > 0);
          steps_left[m] = (steps_left[m] > 0) ? steps_left[m] - 1 : steps_left[m] + 1;
          step_lv[m] = 1'b1;
          phase[m] = PH_HIGH;
          ticks_left[m] = half_ticks(m);
        end
      end
    end else if (code >= CODE_M && code <= CODE_P) begin
      m = int'(code - CODE_M);
      delta = longint'(amt) * longint'(mult_shadow);
      acc = longint'(steps_left[m]);
      acc = (arg != 8'd0) ? acc + delta : acc - delta;
      if (acc > STEP_MAX) acc = STEP_MAX;
      if (acc < STEP_MIN) acc = STEP_MIN;
      steps_left[m] = acc[COUNT_WIDTH-1:0];
    end else if (code == CODE_T && arg >= 8'd1 && arg <= MOTOR_COUNT) begin
      dis_lv[arg - 8'd1] = ~dis_lv[arg - 8'd1];
    end
    r.step = step_lv;
    r.dir = dir_lv;
    r.dis = dis_lv;
    r.busy = 1'b0;
    for (m = 0; m < MOTOR_COUNT; m++)
      if (steps_left[m] != 0 || phase[m] != PH_IDLE) r.busy = 1'b1;
    return r;
  endfunction

  function automatic void compare_field(string label, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, label, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic check_levels(input logic [OUT_DATA_W-1:0] seen);
    levels_t want;
    if (pending_levels.size() == 0) begin
      $display("%0t: unexpected result transaction, expected none, got %h", $time, seen);
      mismatch_count++;
      return;
    end
    want = pending_levels.pop_front();
    compare_field("step_lines", want.step, seen[3:0]);
    compare_field("dir_lines", want.dir, seen[7:4]);
    compare_field("disable_lines", want.dis, seen[11:8]);
    compare_field("busy", {3'b000, want.busy}, {3'b000, seen[12]});
  endtask

  task automatic send_item(input logic is_tick, input logic [7:0] code, arg, amt,
                           input logic typed, input levels_t typed_want);
    levels_t predicted;
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= is_tick;
    in_tdata <= {amt, arg, code};
    do @(posedge clk); while (in_tready !== 1'b1);
    predicted = advance_sequencer(is_tick, code, arg, amt);
    pending_levels.push_back(typed ? typed_want : predicted);
    if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_settings(input logic [7:0] mult, h1, h2, h3, h4);
    logic [7:0] vals [5];
    vals = '{mult, h1, h2, h3, h4};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_ORDER[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    mult_shadow = mult;
    half_shadow = '{h1, h2, h3, h4};
  endtask

  // hammer mode drives motor 4 hard in one direction to reach the counter limits
  task automatic run_mix(input int count, input bit hammer, input bit up);
    int r;
    logic tick;
    logic [7:0] code, arg, amt;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      code = $urandom;
      arg = $urandom;
      amt = $urandom;
      tick = 1'b0;
      if (hammer) begin
        if (r < 10) begin
          tick = 1'b1;
        end else begin
          code = CODE_P;
          arg = up ? 8'($urandom_range(1, 255)) : 8'h00;
          amt = 8'($urandom_range(220, 255));
        end
      end else if (r < 50) begin
        tick = 1'b1;
      end else if (r < 82) begin
        code = CODE_M + 8'($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 0) arg = 8'h00;
        if ($urandom_range(0, 7) != 0) amt = 8'($urandom_range(0, 3));
      end else if (r < 92) begin
        code = CODE_T;
        if ($urandom_range(0, 7) != 0) arg = 8'($urandom_range(1, 4));
      end
      send_item(tick, code, arg, amt, 1'b0, '0);
      if (!hammer && $urandom_range(0, 79) == 0) drain();
    end
  endtask

  initial begin
    int stall;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      check_levels(out_tdata);
      if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("tb_four_axis_step_command_sequencer failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < $size(SCRIPT); i++)
      send_item(SCRIPT[i].tick, SCRIPT[i].code, SCRIPT[i].arg, SCRIPT[i].amt,
                SCRIPT[i].typed, SCRIPT[i].want);
    drain();
    load_settings(8'd1, 8'd1, 8'd2, 8'd3, 8'd4);
    run_mix(120, 1'b0, 1'b0);
    drain();
    load_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    run_mix(120, 1'b0, 1'b0);
    drain();
    load_settings(8'd3, 8'd255, 8'd1, 8'd2, 8'd255);
    run_mix(120, 1'b0, 1'b0);
    drain();
    load_settings(MULT_RST, HALF1_RST, HALF2_RST, HALF3_RST, HALF4_RST);
    run_mix(115, 1'b0, 1'b0);
    drain();
    load_settings(8'd255, 8'($urandom_range(1, 3)), 8'($urandom_range(1, 3)),
                  8'($urandom_range(1, 3)), 8'($urandom_range(1, 3)));
    run_mix(190, 1'b1, 1'b1);
    run_mix(360, 1'b1, 1'b0);
    drain();
    if (mismatch_count == 0) begin
      $display("tb_four_axis_step_command_sequencer passed");
    end else begin
      $display("tb_four_axis_step_command_sequencer failed");
    end
    $finish;
  end

endmodule
